// File: rtl/core/stlq_pkg.sv
// Shared types and constants for the SPI transfer lock and request queue.
`timescale 1ns / 1ps
`default_nettype none

package stlq_pkg;

   // Field widths fixed by the transfer descriptor format.
   localparam int ADDR_W        = 32;
   localparam int BYTE_COUNT_W  = 12;
   localparam int SLAVE_SEL_W   = 2;
   localparam int FLAGS_W       = 3;
   localparam int TAG_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int BYTE_COUNT_MAX = (1 << BYTE_COUNT_W) - 1;

   // Item kinds carried in the action field.
   localparam logic ACTION_REQUEST = 1'b0;
   localparam logic ACTION_DONE    = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_STARTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd3;

   // One incoming request or completion.
   typedef struct packed {
      logic                    action;
      logic [ADDR_W-1:0]       send_addr;
      logic [ADDR_W-1:0]       recv_addr;
      logic                    recv_enable;
      logic [BYTE_COUNT_W-1:0] byte_count;
      logic [SLAVE_SEL_W-1:0]  slave_sel;
      logic [FLAGS_W-1:0]      xfer_flags;
      logic [TAG_W-1:0]        done_tag;
   } stlq_req_type;

   // One result.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    launch;
      logic [ADDR_W-1:0]       out_send_addr;
      logic [ADDR_W-1:0]       out_recv_addr;
      logic                    out_recv_enable;
      logic [BYTE_COUNT_W-1:0] out_byte_count;
      logic [SLAVE_SEL_W-1:0]  out_slave_sel;
      logic [FLAGS_W-1:0]      out_flags;
      logic [TAG_W-1:0]        out_tag;
   } stlq_rsp_type;

   // A queued transfer descriptor as held in the descriptor memory.
   typedef struct packed {
      logic [ADDR_W-1:0]       send_addr;
      logic [ADDR_W-1:0]       recv_addr;
      logic                    recv_enable;
      logic [BYTE_COUNT_W-1:0] byte_count;
      logic [SLAVE_SEL_W-1:0]  slave_sel;
      logic [FLAGS_W-1:0]      flags;
      logic [TAG_W-1:0]        tag;
   } stlq_desc_type;

endpackage

`default_nettype wire

// File: rtl/core/stlq_desc_mem.sv
// Descriptor memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stlq_desc_mem
   import stlq_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire stlq_desc_type     wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output stlq_desc_type          rd_data
);

   stlq_desc_type mem_ff [DEPTH];
   stlq_desc_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/spi_transfer_lock_queue.sv
// Top level: SPI bus lock with a circular queue of pending transfer descriptors.
// A request gives its result in the cycle after it is accepted; busy stays low.
// A done item that pops the queue holds busy high for one cycle while the
// descriptor memory is read; its result passes the read and result registers.
// Other done items answer in the next cycle. Rate: one item per cycle while busy is low.
// Synchronous reset frees the bus and empties the queue; busy is high during reset.
`timescale 1ns / 1ps
`default_nettype none

module spi_transfer_lock_queue
   import stlq_pkg::*;
#(
   parameter int QUEUE_SLOTS    = 8,
   parameter int MAX_XFER_BYTES = 4095
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire stlq_req_type req_data,
   output logic              strobe,
   output stlq_rsp_type      rsp_data
);

   localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
   localparam logic [BYTE_COUNT_W-1:0] COUNT_LIMIT =
      (MAX_XFER_BYTES > BYTE_COUNT_MAX) ? BYTE_COUNT_W'(BYTE_COUNT_MAX)
                                        : BYTE_COUNT_W'(MAX_XFER_BYTES);

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

   state_type     state_ff, state_in;
   logic          bus_busy_ff, bus_busy_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic          strobe_ff, strobe_in;
   stlq_rsp_type  rsp_ff, rsp_in;

   logic          accept;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic          queue_empty;
   logic          queue_full;
   stlq_desc_type req_desc;
   stlq_desc_type rd_desc;
   logic          mem_wr_en;
   logic          mem_rd_en;

   assign accept = start && !busy;

   // Circular pointer arithmetic; one slot always stays empty.
   assign head_next   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_next   = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign queue_empty = (head_ff == tail_ff);
   assign queue_full  = (tail_next == head_ff);

   // Build the descriptor of a request, with the byte count saturated.
   always_comb begin
      req_desc.send_addr   = req_data.send_addr;
      req_desc.recv_addr   = req_data.recv_addr;
      req_desc.recv_enable = req_data.recv_enable;
      req_desc.byte_count  = (req_data.byte_count > COUNT_LIMIT) ? COUNT_LIMIT
                                                                 : req_data.byte_count;
      req_desc.slave_sel   = req_data.slave_sel;
      req_desc.flags       = req_data.xfer_flags;
      req_desc.tag         = req_data.done_tag;
   end

   stlq_desc_mem #(
      .DEPTH  (QUEUE_SLOTS),
      .ADDR_W (PTR_W)
   ) u_desc_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_desc),
      .rd_en   (mem_rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_desc)
   );

   // Next-state logic for the lock, the queue pointers and the result.
   always_comb begin
      state_in    = state_ff;
      bus_busy_in = bus_busy_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      strobe_in   = 1'b0;
      rsp_in      = '0;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_REQUEST) begin
                  strobe_in = 1'b1;
                  if (!bus_busy_ff) begin
                     bus_busy_in            = 1'b1;
                     rsp_in.status          = STATUS_STARTED;
                     rsp_in.launch          = 1'b1;
                     rsp_in.out_send_addr   = req_desc.send_addr;
                     rsp_in.out_recv_addr   = req_desc.recv_addr;
                     rsp_in.out_recv_enable = req_desc.recv_enable;
                     rsp_in.out_byte_count  = req_desc.byte_count;
                     rsp_in.out_slave_sel   = req_desc.slave_sel;
                     rsp_in.out_flags       = req_desc.flags;
                     rsp_in.out_tag         = req_desc.tag;
                  end else if (queue_full) begin
                     rsp_in.status = STATUS_REJECTED;
                  end else begin
                     mem_wr_en     = 1'b1;
                     tail_in       = tail_next;
                     rsp_in.status = STATUS_QUEUED;
                  end
               end else if (bus_busy_ff && !queue_empty) begin
                  // Pop the oldest descriptor; the result follows the read.
                  mem_rd_en = 1'b1;
                  head_in   = head_next;
                  state_in  = ST_POP;
               end else begin
                  bus_busy_in   = 1'b0;
                  strobe_in     = 1'b1;
                  rsp_in.status = STATUS_IDLE;
               end
            end
         end
         ST_POP: begin
            strobe_in              = 1'b1;
            rsp_in.status          = STATUS_STARTED;
            rsp_in.launch          = 1'b1;
            rsp_in.out_send_addr   = rd_desc.send_addr;
            rsp_in.out_recv_addr   = rd_desc.recv_addr;
            rsp_in.out_recv_enable = rd_desc.recv_enable;
            rsp_in.out_byte_count  = rd_desc.byte_count;
            rsp_in.out_slave_sel   = rd_desc.slave_sel;
            rsp_in.out_flags       = rd_desc.flags;
            rsp_in.out_tag         = rd_desc.tag;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, pointers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bus_busy_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         bus_busy_ff <= bus_busy_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         strobe_ff   <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign busy     = reset || (state_ff == ST_POP);
   assign strobe   = strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/stlq_checker.sv
// Port-level checker for the SPI transfer lock queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module stlq_checker
   import stlq_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire stlq_req_type req_data,
   input wire logic         strobe,
   input wire stlq_rsp_type rsp_data
);

   // An accepted request is answered in the next cycle.
   a_request_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == ACTION_REQUEST) |=> strobe)
      else $error("request transfer not answered in the next cycle");

   // A result launches a transfer exactly when its status says started.
   a_launch_status: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_data.launch == (rsp_data.status == STATUS_STARTED)))
      else $error("launch flag disagrees with status");

   // Without a launch the descriptor fields are all zero.
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (strobe && !rsp_data.launch) |->
         (rsp_data.out_send_addr == '0 && rsp_data.out_recv_addr == '0 &&
          rsp_data.out_recv_enable == 1'b0 && rsp_data.out_byte_count == '0 &&
          rsp_data.out_slave_sel == '0 && rsp_data.out_flags == '0 &&
          rsp_data.out_tag == '0))
      else $error("descriptor fields not cleared on a result without launch");

   // A queue pop holds busy for one cycle and then delivers its result.
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (strobe && rsp_data.launch))
      else $error("queue pop ended without a launched result");

endmodule

bind spi_transfer_lock_queue stlq_checker u_stlq_checker (.*);

`default_nettype wire
